// ===== src/olwd_pkg.sv =====
// Shared types and codes for the ordered list with delete.
// Used by olwd_cell and ordered_list_with_delete_core; no dependencies.
package olwd_pkg;

    typedef logic signed [31:0] t_data;
    typedef logic [1:0]         t_action;
    typedef logic [1:0]         t_status;
    typedef logic [2:0]         t_cell_op;

    localparam t_action ACT_APPEND  = 2'd0;
    localparam t_action ACT_PREPEND = 2'd1;
    localparam t_action ACT_DELETE  = 2'd2;
    localparam t_action ACT_DUMP    = 2'd3;

    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_NOT_FOUND = 2'd1;
    localparam t_status STAT_FULL      = 2'd2;
    localparam t_status STAT_EMPTY     = 2'd3;

    localparam t_cell_op OP_HOLD    = 3'd0;
    localparam t_cell_op OP_APPEND  = 3'd1;
    localparam t_cell_op OP_PREPEND = 3'd2;
    localparam t_cell_op OP_CMP     = 3'd3;
    localparam t_cell_op OP_DELETE  = 3'd4;
    localparam t_cell_op OP_ROTATE  = 3'd5;

endpackage

// ===== src/ordered_list_with_delete_core.sv =====
// Ordered list with delete: append, prepend, delete first match, dump.
// Append, prepend and empty dump give a registered result; delete runs the compare pass (S_MATCH)
// then the shift pass (S_DELETE) through the cell chain; dump enters S_DUMP before its first entry.
// One item per cycle (insert, empty dump) if output is free; delete and dump take no new request
// until done. Dump streams one entry per cycle unless stalled, rotating the chain back into place.
// Reset (synchronous, active low) clears count, cell valid bits and the controller.
module ordered_list_with_delete_core #(
    parameter int DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  olwd_pkg::t_action i_action,
    input  olwd_pkg::t_data   i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output olwd_pkg::t_status o_status,
    output olwd_pkg::t_data   o_entry,
    output logic              o_last
);
    import olwd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_DELETE = 2'd2;
    localparam logic [1:0] S_DUMP   = 2'd3;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;
    t_data       r_value;
    logic        r_out_valid;
    logic        n_out_valid;
    t_status     r_status;
    t_status     n_status;
    t_data       r_entry;
    t_data       n_entry;
    logic        r_last;
    logic        n_last;

    t_cell_op    w_op;
    t_data       w_bcast;
    logic        w_out_free;
    logic        w_accept;
    logic        w_full;
    logic        w_any_found;

    t_data       w_data  [DEPTH];
    logic        w_valid [DEPTH];
    logic        w_found [DEPTH];

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_bcast     = (r_state == S_IDLE) ? i_value : r_value;
    assign w_any_found = w_found[DEPTH-1];

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_entry     = r_entry;
    assign o_last      = r_last;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_data w_prev_data;
        logic  w_prev_valid;
        t_data w_next_data;
        logic  w_next_valid;
        logic  w_found_in;

        if (g == 0) begin : g_first
            assign w_prev_data  = w_bcast;
            assign w_prev_valid = 1'b1;
            assign w_found_in   = 1'b0;
        end else begin : g_mid
            assign w_prev_data  = w_data[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_found_in   = w_found[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_data  = w_data[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        olwd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_bcast      (w_bcast),
            .i_head       (w_data[0]),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .i_found      (w_found_in),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g]),
            .o_found      (w_found[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        w_op        = OP_HOLD;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_entry     = r_entry;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        ACT_APPEND, ACT_PREPEND: begin
                            n_out_valid = 1'b1;
                            n_entry     = '0;
                            n_last      = 1'b1;
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_status = STAT_OK;
                                n_count  = r_count + CW'(1);
                                w_op     = (i_action == ACT_APPEND) ? OP_APPEND : OP_PREPEND;
                            end
                        end
                        ACT_DELETE: begin
                            n_state = S_MATCH;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = STAT_EMPTY;
                                n_entry     = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_left  = r_count;
                                n_state = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_MATCH: begin
                w_op    = OP_CMP;
                n_state = S_DELETE;
            end
            S_DELETE: begin
                w_op        = OP_DELETE;
                n_out_valid = 1'b1;
                n_entry     = '0;
                n_last      = 1'b1;
                n_state     = S_IDLE;
                if (w_any_found) begin
                    n_status = STAT_OK;
                    n_count  = r_count - CW'(1);
                end else begin
                    n_status = STAT_NOT_FOUND;
                end
            end
            default: begin
                if (w_out_free) begin
                    w_op        = OP_ROTATE;
                    n_out_valid = 1'b1;
                    n_status    = STAT_OK;
                    n_entry     = w_data[0];
                    n_last      = (r_left == CW'(1));
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_last   <= n_last;
        if (w_accept) begin
            r_value <= i_value;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/olwd_cell.sv =====
// One storage cell of the list chain: holds an entry and its valid bit.
// Depends on olwd_pkg for the data type and cell operation codes.
module olwd_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  olwd_pkg::t_cell_op i_op,
    input  olwd_pkg::t_data   i_bcast,
    input  olwd_pkg::t_data   i_head,
    input  olwd_pkg::t_data   i_prev_data,
    input  logic              i_prev_valid,
    input  olwd_pkg::t_data   i_next_data,
    input  logic              i_next_valid,
    input  logic              i_found,
    output olwd_pkg::t_data   o_data,
    output logic              o_valid,
    output logic              o_found
);
    import olwd_pkg::*;

    t_data r_data;
    t_data n_data;
    logic  r_valid;
    logic  n_valid;
    logic  r_match;
    logic  n_match;

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_found = i_found | r_match;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        n_match = r_match;
        case (i_op)
            OP_APPEND: begin
                if (!r_valid && i_prev_valid) begin
                    n_data  = i_bcast;
                    n_valid = 1'b1;
                end
            end
            OP_PREPEND: begin
                n_data  = i_prev_data;
                n_valid = i_prev_valid;
            end
            OP_CMP: begin
                n_match = r_valid && (r_data == i_bcast);
            end
            OP_DELETE: begin
                if (o_found) begin
                    n_data  = i_next_data;
                    n_valid = i_next_valid;
                end
            end
            OP_ROTATE: begin
                if (i_next_valid) begin
                    n_data = i_next_data;
                end else if (r_valid) begin
                    n_data = i_head;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule
